// ----- rtl/core/tps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg: shared types and codes of the task priority scheduler
// Request and response payloads, table entry layout, opcodes, status codes
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int ID_BITS       = 16;
    localparam int PRIORITY_BITS = 32;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_EDIT = 2'd1;
    localparam logic [1:0] OP_REM  = 2'd2;
    localparam logic [1:0] OP_EXEC = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [ID_BITS-1:0]       user_id;
        logic [ID_BITS-1:0]       task_id;
        logic [PRIORITY_BITS-1:0] priority_req;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_BITS-1:0] top_user;
    } t_rsp;

    typedef struct packed {
        logic                     valid;
        logic [ID_BITS-1:0]       task_id;
        logic [ID_BITS-1:0]       user_id;
        logic [PRIORITY_BITS-1:0] prio;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic load_req;   // capture the accepted request, reset scan trackers
        logic rd_en;      // read the table entry at the scan address
        logic clear_wr;   // write an empty entry at the scan address
        logic commit;     // apply the operation and load the response
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // response register can take a new response
    } t_sts;

endpackage

// ----- rtl/core/tps_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_datapath: task table, scan trackers and response register
// Holds the table memory, walks it one entry a cycle under controller
// command, then applies the operation and registers the response.
// ----------------------------------------------------------------------------
module tps_datapath #(
    parameter int SLOTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tps_pkg::t_req                 i_req,
    input  tps_pkg::t_cmd                 i_cmd,
    input  logic [$clog2(SLOTS)-1:0]      i_addr,
    output tps_pkg::t_sts                 o_sts,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output tps_pkg::t_rsp                 o_rsp
);
    import tps_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);

    t_entry              r_mem [SLOTS];
    t_entry              r_rd_data;
    logic [ADDR_W-1:0]   r_rd_idx;
    logic                r_rd_vld;

    t_req                r_req;

    logic                r_match_found;
    logic [ADDR_W-1:0]   r_match_idx;
    logic [ID_BITS-1:0]  r_match_user;
    logic                r_free_found;
    logic [ADDR_W-1:0]   r_free_idx;
    logic                r_best_found;
    logic [ADDR_W-1:0]   r_best_idx;
    logic [PRIORITY_BITS-1:0] r_best_prio;
    logic [ID_BITS-1:0]  r_best_task;
    logic [ID_BITS-1:0]  r_best_user;

    logic                r_out_valid;
    t_rsp                r_out;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    t_entry              wr_data;
    logic                op_we;
    logic [ADDR_W-1:0]   op_addr;
    t_entry              op_data;
    t_rsp                op_rsp;
    logic                hit_match;
    logic                hit_free;
    logic                hit_best;

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_addr];
            r_rd_idx  <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_comb begin
        hit_match = r_rd_data.valid && (r_rd_data.task_id == r_req.task_id) && !r_match_found;
        hit_free  = !r_rd_data.valid && !r_free_found;
        hit_best  = r_rd_data.valid &&
                    (!r_best_found || (r_rd_data.prio > r_best_prio) ||
                     ((r_rd_data.prio == r_best_prio) && (r_rd_data.task_id > r_best_task)));
    end

    // Scan trackers: first match, first free slot, best entry so far
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_best_found  <= 1'b0;
        end else if (i_cmd.load_req) begin
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_best_found  <= 1'b0;
        end else if (r_rd_vld) begin
            if (hit_match) begin
                r_match_found <= 1'b1;
            end
            if (hit_free) begin
                r_free_found <= 1'b1;
            end
            if (hit_best) begin
                r_best_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (r_rd_vld && hit_match) begin
            r_match_idx  <= r_rd_idx;
            r_match_user <= r_rd_data.user_id;
        end
        if (r_rd_vld && hit_free) begin
            r_free_idx <= r_rd_idx;
        end
        if (r_rd_vld && hit_best) begin
            r_best_idx  <= r_rd_idx;
            r_best_prio <= r_rd_data.prio;
            r_best_task <= r_rd_data.task_id;
            r_best_user <= r_rd_data.user_id;
        end
    end

    // Apply the operation from the finished scan
    always_comb begin
        op_we           = 1'b0;
        op_addr         = r_match_idx;
        op_data.valid   = 1'b1;
        op_data.task_id = r_req.task_id;
        op_data.user_id = r_req.user_id;
        op_data.prio    = r_req.priority_req;
        op_rsp.status   = ST_OK;
        op_rsp.top_user = '0;
        unique case (r_req.opcode)
            OP_ADD: begin
                if (r_match_found) begin
                    op_we = 1'b1;
                end else if (r_free_found) begin
                    op_we   = 1'b1;
                    op_addr = r_free_idx;
                end else begin
                    op_rsp.status = ST_FULL;
                end
            end
            OP_EDIT: begin
                op_data.user_id = r_match_user;
                op_we           = r_match_found;
                if (!r_match_found) begin
                    op_rsp.status = ST_NOT_FOUND;
                end
            end
            OP_REM: begin
                op_data.valid = 1'b0;
                op_we         = r_match_found;
                if (!r_match_found) begin
                    op_rsp.status = ST_NOT_FOUND;
                end
            end
            OP_EXEC: begin
                op_data.valid = 1'b0;
                op_addr       = r_best_idx;
                op_we         = r_best_found;
                if (r_best_found) begin
                    op_rsp.top_user = r_best_user;
                end else begin
                    op_rsp.status = ST_NOT_FOUND;
                end
            end
        endcase
    end

    always_comb begin
        wr_en   = i_cmd.clear_wr || (i_cmd.commit && op_we);
        wr_addr = i_cmd.clear_wr ? i_addr : op_addr;
        wr_data = op_data;
        if (i_cmd.clear_wr) begin
            wr_data.valid = 1'b0;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= op_rsp;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid    = r_out_valid;
    assign o_rsp          = r_out;

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_rsp_ready))
        else $error("commit while response register is occupied");

    a_commit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("response not loaded after commit");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.commit && (i_cmd.rd_en || i_cmd.clear_wr || i_cmd.load_req)))
        else $error("commit overlaps another datapath command");

endmodule

// ----- rtl/core/tps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_ctrl: sequencer of the task priority scheduler
// Clears the table after reset, then per request runs a full table scan
// and commits the operation once the response register is free.
// ----------------------------------------------------------------------------
module tps_ctrl #(
    parameter int SLOTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  tps_pkg::t_sts                 i_sts,
    output tps_pkg::t_cmd                 o_cmd,
    output logic [$clog2(SLOTS)-1:0]      o_addr
);
    import tps_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] n_cnt;
    logic              last;

    assign last = (r_cnt == ADDR_W'(SLOTS - 1));

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd.load_req = 1'b0;
        o_cmd.rd_en    = 1'b0;
        o_cmd.clear_wr = 1'b0;
        o_cmd.commit   = 1'b0;
        o_req_ready    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                n_cnt          = last ? '0 : r_cnt + 1'b1;
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_cnt       = last ? '0 : r_cnt + 1'b1;
                if (last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_addr = r_cnt;

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_SCAN && r_cnt == '0))
        else $error("scan did not start at slot zero after accept");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && last) |=> (r_state == S_IDLE))
        else $error("clear pass did not end after the last slot");

    a_scan_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && last) |=> (r_state == S_DRAIN))
        else $error("scan did not stop after the last slot");

endmodule

// ----- rtl/core/task_priority_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_priority_scheduler: table based priority scheduler of tasks
// Add, edit, remove and execute-top over a table of SLOTS live tasks.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_req_valid / o_req_ready carries t_req (opcode,
//   user_id, task_id, priority_req). Response channel o_rsp_valid /
//   i_rsp_ready carries t_rsp (status, top_user); one response per request.
//   Each request scans the whole table, one entry a cycle through the
//   table memory read port, then commits the update in one write.
//   A request is accepted in idle, then scanned, drained and committed
//   before the next accept; its response is registered at commit.
//   Execute-top returns the highest priority task, ties to the larger id.
//   After reset a clearing pass marks every slot empty, one per cycle;
//   no request is taken until it ends.
//   A stalled receiver holds the response in the output register; the
//   next request is still accepted and scanned, and its commit waits
//   until the held response is taken.
// ----------------------------------------------------------------------------
module task_priority_scheduler #(
    parameter int SLOTS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  tps_pkg::t_req   i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output tps_pkg::t_rsp   o_rsp
);
    import tps_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);

    t_cmd              cmd;
    t_sts              sts;
    logic [ADDR_W-1:0] addr;

    // Sequencer: clear pass, scan, commit
    tps_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    // Table memory, scan trackers and response register
    tps_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .i_addr      (addr),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule
